// File: rtl/ovg_pkg.sv
// shared types and constants for the overlap interval grouper
`default_nettype none

package ovg_pkg;

   localparam int unsigned POS_W  = 32;
   localparam int unsigned BIDX_W = 6;

   typedef struct packed {
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
   } span_type;

endpackage

`default_nettype wire

// File: rtl/overlap_interval_grouper.sv
// top level of the overlap interval grouper: front queue plus block table scanner
// scan: blocks are examined in order from block 0 and a read joins the first block that it
//    overlaps, so blocks 0 to k-1 are examined first; it appends or overflows when none of the
//    stored blocks overlaps; one read is handled at a time, each entry read in S_RD and compared
//    in S_CMP over the single read port of the block table; a two-entry queue decouples input
// reset: clears the block count, the queue and the response valid flag; table contents are kept
`default_nettype none

module overlap_interval_grouper
   import ovg_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 64
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [POS_W-1:0]  req_first_pos,
   input  wire logic [POS_W-1:0]  req_last_pos,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BIDX_W-1:0]      rsp_block_index,
   output logic                   rsp_new_block,
   output logic                   rsp_overflow,
   output logic [POS_W-1:0]       rsp_span_low,
   output logic [POS_W-1:0]       rsp_span_high
);

   logic     q_valid;
   span_type q_item;
   logic     q_pop;

   ovg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_first_pos (req_first_pos),
      .req_last_pos  (req_last_pos),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   ovg_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_index (rsp_block_index),
      .rsp_new_block   (rsp_new_block),
      .rsp_overflow    (rsp_overflow),
      .rsp_span_low    (rsp_span_low),
      .rsp_span_high   (rsp_span_high)
   );

endmodule

`default_nettype wire

// File: rtl/ovg_front.sv
// front end: accepts read spans, orders their ends and queues them for the scanner
`default_nettype none

module ovg_front
   import ovg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [POS_W-1:0] req_first_pos,
   input  wire logic [POS_W-1:0] req_last_pos,
   output logic                  q_valid,
   output span_type              q_item,
   input  wire logic             q_pop
);

   span_type   buf_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;
   span_type   item;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = buf_ff[rd_ptr_ff];

   // reversed spans are swapped
   always_comb begin
      if (req_first_pos > req_last_pos) begin
         item.lo = req_last_pos;
         item.hi = req_first_pos;
      end else begin
         item.lo = req_first_pos;
         item.hi = req_last_pos;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ovg_back.sv
// back end: scans the block table, updates or appends a block and holds the result
`default_nettype none

module ovg_back
   import ovg_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 64
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire span_type          q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BIDX_W-1:0]      rsp_block_index,
   output logic                   rsp_new_block,
   output logic                   rsp_overflow,
   output logic [POS_W-1:0]       rsp_span_low,
   output logic [POS_W-1:0]       rsp_span_high
);

   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_CMP  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   span_type          cur_ff;
   span_type          cur_in;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  idx_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [IDX_W-1:0]  res_idx_ff;
   logic [IDX_W-1:0]  res_idx_in;
   span_type          res_span_ff;
   span_type          res_span_in;
   logic              res_new_ff;
   logic              res_new_in;
   logic              res_ovf_ff;
   logic              res_ovf_in;
   logic              res_wr_ff;
   logic              res_wr_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BIDX_W-1:0] rsp_idx_ff;
   logic [BIDX_W-1:0] rsp_idx_in;
   logic              rsp_new_ff;
   logic              rsp_new_in;
   logic              rsp_ovf_ff;
   logic              rsp_ovf_in;
   span_type          rsp_span_ff;
   span_type          rsp_span_in;
   logic              load_rsp;

   span_type          mem [MAX_BLOCKS];
   span_type          rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   assign rd_addr = idx_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      res_idx_in   = res_idx_ff;
      res_span_in  = res_span_ff;
      res_new_in   = res_new_ff;
      res_ovf_in   = res_ovf_ff;
      res_wr_in    = res_wr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_span_in  = rsp_span_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (idx_ff == cnt_ff) begin
               if (cnt_ff == FULL) begin
                  res_idx_in  = '0;
                  res_span_in = '0;
                  res_new_in  = 1'b0;
                  res_ovf_in  = 1'b1;
                  res_wr_in   = 1'b0;
               end else begin
                  res_idx_in  = cnt_ff[IDX_W-1:0];
                  res_span_in = cur_ff;
                  res_new_in  = 1'b1;
                  res_ovf_in  = 1'b0;
                  res_wr_in   = 1'b1;
               end
               state_in = S_OUT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_data_ff.lo <= cur_ff.hi && cur_ff.lo <= rd_data_ff.hi) begin
               res_idx_in     = idx_ff[IDX_W-1:0];
               res_span_in.lo = (cur_ff.lo < rd_data_ff.lo) ? cur_ff.lo : rd_data_ff.lo;
               res_span_in.hi = (cur_ff.hi > rd_data_ff.hi) ? cur_ff.hi : rd_data_ff.hi;
               res_new_in     = 1'b0;
               res_ovf_in     = 1'b0;
               res_wr_in      = 1'b1;
               state_in       = S_OUT;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_RD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               wr_en        = res_wr_ff;
               cnt_in       = cnt_ff + CNT_W'(res_new_ff);
               rsp_valid_in = 1'b1;
               rsp_idx_in   = BIDX_W'(res_idx_ff);
               rsp_new_in   = res_new_ff;
               rsp_ovf_in   = res_ovf_ff;
               rsp_span_in  = res_span_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      res_idx_ff  <= res_idx_in;
      res_span_ff <= res_span_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      res_wr_ff   <= res_wr_in;
      if (load_rsp) begin
         rsp_idx_ff  <= rsp_idx_in;
         rsp_new_ff  <= rsp_new_in;
         rsp_ovf_ff  <= rsp_ovf_in;
         rsp_span_ff <= rsp_span_in;
      end
   end

   // block table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[res_idx_ff] <= res_span_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_index = rsp_idx_ff;
   assign rsp_new_block   = rsp_new_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_span_low    = rsp_span_ff.lo;
   assign rsp_span_high   = rsp_span_ff.hi;

endmodule

`default_nettype wire
